FILE: sv/iirbq_pkg.sv
// Shared types, widths and codes of the biquad cascade filter.
package iirbq_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned HIST_W    = 48;
  localparam int unsigned LO_W      = 24;
  localparam int unsigned OPA_W     = LO_W + 1;
  localparam int unsigned OPB_W     = COEF_W + 1;
  localparam int unsigned PROD_W    = OPA_W + OPB_W;
  localparam int unsigned ACC_W     = 96;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned NSEC_W    = 4;
  localparam int unsigned GMAN_W    = 31;
  localparam int unsigned GSH_W     = 6;
  localparam int unsigned SH_W      = 7;
  localparam int unsigned GAIN_FRAC = 31;
  localparam int unsigned CFG_AW    = 2;
  localparam int unsigned CFG_DW    = 31;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned CSEC_W    = 3;
  localparam int unsigned TAP_W     = 2;

  localparam logic [ACT_W-1:0] ACT_FILTER = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_NUM_SECTIONS  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_GAIN_MANTISSA = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_GAIN_SHIFT    = 2'd2;

  // tap order: coefficient b1/b2/a1/a2 pairs with history x1/x2/y1/y2
  localparam logic [TAP_W-1:0] TAP_X1 = 2'd0;
  localparam logic [TAP_W-1:0] TAP_X2 = 2'd1;
  localparam logic [TAP_W-1:0] TAP_Y1 = 2'd2;
  localparam logic [TAP_W-1:0] TAP_Y2 = 2'd3;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef struct packed {
    logic [ACT_W-1:0]           action;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CSEC_W-1:0]          coef_section;
    logic [TAP_W-1:0]           coef_which;
    logic signed [COEF_W-1:0]   coef_value;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
  } rsp_t;

  typedef struct packed {
    logic             ld_sample;
    logic             coef_wr;
    logic             hist_clr;
    logic             rd_en;
    logic             hist_wr;
    logic [TAP_W-1:0] tap;
    logic             hold_x1;
    logic             hold_y1;
    logic             mul_en;
    logic             mul_hi;
    logic             gain;
    acc_op_e          acc_op;
    logic             acc_shift;
    logic             rnd_en;
    logic             fin_en;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

FILE: sv/iirbq_stream_if.sv
// Valid/ready stream channel carrying one request or result.
interface iirbq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/iir_biquad_cascade_filter_core.sv
// Top level of the biquad cascade filter: sequencer plus datapath.
//
//  channel   dir   payload                                          handshake
//  req_i     in    action, sample, coef_section, coef_which, coef_value   valid/ready
//  rsp_o     out   filtered                                         valid/ready
//  cfg       in    cfg_addr_i, cfg_wdata_i                          cfg_we_i
//
// A filter request walks the n sections in use (capped at MAX_SECTIONS) and then
// the gain stage; each section runs four 48x32 products through one 25x33 multiplier
// in two halves. Loads, clears and unused actions finish without leaving idle.
// Reset loads config defaults and clears both memories' valid bits; no clearing pass.
// A result held on rsp_o only stalls the final gain step of the next request.
module iir_biquad_cascade_filter_core #(
  parameter int unsigned MAX_SECTIONS   = 8,
  parameter int unsigned COEF_FRAC_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iirbq_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [iirbq_pkg::CFG_DW-1:0]  cfg_wdata_i,
  iirbq_stream_if.sink                  req_i,
  iirbq_stream_if.source                rsp_o
);

  localparam int unsigned SCW = $clog2(MAX_SECTIONS + 1);

  iirbq_pkg::dp_cmd_t cmd;
  iirbq_pkg::dp_sts_t sts;
  iirbq_pkg::rsp_t    rsp_data;
  iirbq_pkg::req_t    req_data;
  logic [SCW-1:0]     sec, n_sec;
  logic               req_ready, rsp_vld;

  assign req_data    = req_i.data;
  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_vld;
  assign rsp_o.data  = rsp_data;

  iirbq_ctrl #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_data.action),
    .req_ready_o  (req_ready),
    .n_sec_i      (n_sec),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .sec_o        (sec)
  );

  iirbq_dp #(
    .MAX_SECTIONS   (MAX_SECTIONS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_data),
    .cmd_i       (cmd),
    .sec_i       (sec),
    .n_sec_o     (n_sec),
    .sts_o       (sts),
    .rsp_rdy_i   (rsp_o.ready),
    .rsp_vld_o   (rsp_vld),
    .rsp_data_o  (rsp_data)
  );

  // a result only appears out of the gain stage, never while requests are taken
  a_rsp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_vld) |-> $past(!req_ready))
    else $error("result appeared while idle");

  a_fin_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.fin_en && cmd.gain) |=> rsp_vld)
    else $error("gain finish did not raise result valid");

  a_idle_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_ready && $past(req_ready) && rsp_vld && $past(rsp_vld)) |-> $stable(rsp_data))
    else $error("result changed while idle");

endmodule

FILE: sv/iirbq_ctrl.sv
// Sequencer: walks sections and the gain stage, issues datapath commands.
module iirbq_ctrl #(
  parameter int unsigned MAX_SECTIONS = 8,
  localparam int unsigned SCW = $clog2(MAX_SECTIONS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic [iirbq_pkg::ACT_W-1:0]  req_action_i,
  output logic                         req_ready_o,
  input  logic [SCW-1:0]               n_sec_i,
  input  iirbq_pkg::dp_sts_t           sts_i,
  output iirbq_pkg::dp_cmd_t           cmd_o,
  output logic [SCW-1:0]               sec_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SECT = 2'd1;
  localparam logic [1:0] ST_GAIN = 2'd2;

  // section schedule
  localparam logic [3:0] T_RD_X1   = 4'd0;
  localparam logic [3:0] T_LO_X1   = 4'd1;
  localparam logic [3:0] T_RD_X2   = 4'd2;
  localparam logic [3:0] T_LO_X2   = 4'd3;
  localparam logic [3:0] T_RD_Y1   = 4'd4;
  localparam logic [3:0] T_LO_Y1   = 4'd5;
  localparam logic [3:0] T_RD_Y2   = 4'd6;
  localparam logic [3:0] T_LO_Y2   = 4'd7;
  localparam logic [3:0] T_HI_Y2   = 4'd8;
  localparam logic [3:0] T_ACC_END = 4'd9;
  localparam logic [3:0] T_ROUND   = 4'd10;
  localparam logic [3:0] T_FIN     = 4'd11;
  localparam logic [3:0] T_WR_Y1   = 4'd12;

  // gain schedule
  localparam logic [3:0] G_LO    = 4'd0;
  localparam logic [3:0] G_HI    = 4'd1;
  localparam logic [3:0] G_ACC   = 4'd2;
  localparam logic [3:0] G_ROUND = 4'd3;
  localparam logic [3:0] G_FIN   = 4'd4;

  logic [1:0]     state_q, state_d;
  logic [3:0]     step_q, step_d;
  logic [SCW-1:0] sec_q, sec_d;

  assign sec_o = sec_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.acc_op = iirbq_pkg::ACC_HOLD;
    state_d      = state_q;
    step_d       = step_q;
    sec_d        = sec_q;
    req_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          unique case (req_action_i)
            iirbq_pkg::ACT_FILTER: begin
              cmd_o.ld_sample = 1'b1;
              step_d          = '0;
              sec_d           = '0;
              state_d         = (n_sec_i == '0) ? ST_GAIN : ST_SECT;
            end
            iirbq_pkg::ACT_LOAD:  cmd_o.coef_wr  = 1'b1;
            iirbq_pkg::ACT_CLEAR: cmd_o.hist_clr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SECT: begin
        step_d = step_q + 4'd1;
        unique case (step_q)
          T_RD_X1: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.tap    = iirbq_pkg::TAP_X1;
            cmd_o.acc_op = iirbq_pkg::ACC_LOAD_X;
          end
          T_LO_X1: begin
            cmd_o.mul_en  = 1'b1;
            cmd_o.hold_x1 = 1'b1;
          end
          T_RD_X2: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.tap    = iirbq_pkg::TAP_X2;
            cmd_o.mul_en = 1'b1;
            cmd_o.mul_hi = 1'b1;
            cmd_o.acc_op = iirbq_pkg::ACC_ADD;
          end
          T_LO_X2: begin
            cmd_o.mul_en    = 1'b1;
            cmd_o.acc_op    = iirbq_pkg::ACC_ADD;
            cmd_o.acc_shift = 1'b1;
          end
          T_RD_Y1: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.tap    = iirbq_pkg::TAP_Y1;
            cmd_o.mul_en = 1'b1;
            cmd_o.mul_hi = 1'b1;
            cmd_o.acc_op = iirbq_pkg::ACC_ADD;
          end
          T_LO_Y1: begin
            cmd_o.mul_en    = 1'b1;
            cmd_o.hold_y1   = 1'b1;
            cmd_o.acc_op    = iirbq_pkg::ACC_ADD;
            cmd_o.acc_shift = 1'b1;
          end
          T_RD_Y2: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.tap    = iirbq_pkg::TAP_Y2;
            cmd_o.mul_en = 1'b1;
            cmd_o.mul_hi = 1'b1;
            cmd_o.acc_op = iirbq_pkg::ACC_SUB;
          end
          T_LO_Y2: begin
            cmd_o.mul_en    = 1'b1;
            cmd_o.acc_op    = iirbq_pkg::ACC_SUB;
            cmd_o.acc_shift = 1'b1;
            cmd_o.hist_wr   = 1'b1;
            cmd_o.tap       = iirbq_pkg::TAP_X2;
          end
          T_HI_Y2: begin
            cmd_o.mul_en  = 1'b1;
            cmd_o.mul_hi  = 1'b1;
            cmd_o.acc_op  = iirbq_pkg::ACC_SUB;
            cmd_o.hist_wr = 1'b1;
            cmd_o.tap     = iirbq_pkg::TAP_X1;
          end
          T_ACC_END: begin
            cmd_o.acc_op    = iirbq_pkg::ACC_SUB;
            cmd_o.acc_shift = 1'b1;
            cmd_o.hist_wr   = 1'b1;
            cmd_o.tap       = iirbq_pkg::TAP_Y2;
          end
          T_ROUND: cmd_o.rnd_en = 1'b1;
          T_FIN:   cmd_o.fin_en = 1'b1;
          T_WR_Y1: begin
            cmd_o.hist_wr = 1'b1;
            cmd_o.tap     = iirbq_pkg::TAP_Y1;
            step_d        = '0;
            if (sec_q == n_sec_i - SCW'(1)) begin
              state_d = ST_GAIN;
            end else begin
              sec_d = sec_q + SCW'(1);
            end
          end
          default: step_d = '0;
        endcase
      end
      ST_GAIN: begin
        cmd_o.gain = 1'b1;
        step_d     = step_q + 4'd1;
        unique case (step_q)
          G_LO: cmd_o.mul_en = 1'b1;
          G_HI: begin
            cmd_o.mul_en = 1'b1;
            cmd_o.mul_hi = 1'b1;
            cmd_o.acc_op = iirbq_pkg::ACC_LOAD;
          end
          G_ACC: begin
            cmd_o.acc_op    = iirbq_pkg::ACC_ADD;
            cmd_o.acc_shift = 1'b1;
          end
          G_ROUND: cmd_o.rnd_en = 1'b1;
          G_FIN: begin
            step_d = step_q;
            if (sts_i.out_free) begin
              cmd_o.fin_en = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sec_q   <= sec_d;
    end
  end

endmodule

FILE: sv/iirbq_dp.sv
// Datapath: config registers, coefficient and history memories, shared multiplier,
// accumulator, rounding and saturation, result register.
module iirbq_dp #(
  parameter int unsigned MAX_SECTIONS   = 8,
  parameter int unsigned COEF_FRAC_BITS = 28,
  localparam int unsigned SCW = $clog2(MAX_SECTIONS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iirbq_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [iirbq_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  iirbq_pkg::req_t               req_i,
  input  iirbq_pkg::dp_cmd_t            cmd_i,
  input  logic [SCW-1:0]                sec_i,
  output logic [SCW-1:0]                n_sec_o,
  output iirbq_pkg::dp_sts_t            sts_o,
  input  logic                          rsp_rdy_i,
  output logic                          rsp_vld_o,
  output iirbq_pkg::rsp_t               rsp_data_o
);

  localparam int unsigned NE     = MAX_SECTIONS * 4;
  localparam int unsigned AW     = $clog2(NE);
  localparam int unsigned HIST_W = iirbq_pkg::HIST_W;
  localparam int unsigned COEF_W = iirbq_pkg::COEF_W;
  localparam int unsigned ACC_W  = iirbq_pkg::ACC_W;
  localparam int unsigned PROD_W = iirbq_pkg::PROD_W;
  localparam int unsigned LO_W   = iirbq_pkg::LO_W;
  localparam int unsigned OUT_W  = iirbq_pkg::OUT_W;
  localparam int unsigned SH_W   = iirbq_pkg::SH_W;
  localparam int unsigned NSEC_W = iirbq_pkg::NSEC_W;

  // configuration
  logic [NSEC_W-1:0]            num_sec_q;
  logic [iirbq_pkg::GMAN_W-1:0] gain_man_q;
  logic [iirbq_pkg::GSH_W-1:0]  gain_sh_q;
  logic [NSEC_W:0]              ns_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sec_q  <= '0;
      gain_man_q <= '1;
      gain_sh_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        iirbq_pkg::CFG_NUM_SECTIONS:  num_sec_q  <= cfg_wdata_i[NSEC_W-1:0];
        iirbq_pkg::CFG_GAIN_MANTISSA: gain_man_q <= cfg_wdata_i[iirbq_pkg::GMAN_W-1:0];
        iirbq_pkg::CFG_GAIN_SHIFT:    gain_sh_q  <= cfg_wdata_i[iirbq_pkg::GSH_W-1:0];
        default: ;
      endcase
    end
  end

  assign ns_ext  = {1'b0, num_sec_q};
  assign n_sec_o = (32'(ns_ext) > MAX_SECTIONS) ? SCW'(MAX_SECTIONS) : SCW'(ns_ext);

  // memories
  logic [AW-1:0]            rw_addr, ld_addr;
  logic                     ld_ok;
  logic [COEF_W-1:0]        coef_mem [NE];
  logic [NE-1:0]            coef_vld_q;
  logic signed [COEF_W-1:0] coef_rd_q;
  logic [HIST_W-1:0]        hist_mem [NE];
  logic [NE-1:0]            hist_vld_q;
  logic signed [HIST_W-1:0] hist_rd_q;
  logic [HIST_W-1:0]        hist_wdata;
  logic signed [HIST_W-1:0] hold_x1_q, hold_y1_q, x_q;

  assign rw_addr = AW'({sec_i, cmd_i.tap});
  assign ld_addr = AW'({req_i.coef_section, req_i.coef_which});
  assign ld_ok   = 32'(req_i.coef_section) < MAX_SECTIONS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr && ld_ok) begin
      coef_mem[ld_addr] <= req_i.coef_value;
    end
    if (cmd_i.rd_en) begin
      coef_rd_q <= coef_vld_q[rw_addr] ? coef_mem[rw_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
    end else if (cmd_i.coef_wr && ld_ok) begin
      coef_vld_q[ld_addr] <= 1'b1;
    end
  end

  always_comb begin
    unique case (cmd_i.tap)
      iirbq_pkg::TAP_X2: hist_wdata = hold_x1_q;
      iirbq_pkg::TAP_Y2: hist_wdata = hold_y1_q;
      default:           hist_wdata = x_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_wr) begin
      hist_mem[rw_addr] <= hist_wdata;
    end
    if (cmd_i.rd_en) begin
      hist_rd_q <= hist_vld_q[rw_addr] ? hist_mem[rw_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
    end else if (cmd_i.hist_clr) begin
      hist_vld_q <= '0;
    end else if (cmd_i.hist_wr) begin
      hist_vld_q[rw_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_x1) begin
      hold_x1_q <= hist_rd_q;
    end
    if (cmd_i.hold_y1) begin
      hold_y1_q <= hist_rd_q;
    end
  end

  // shared multiplier, one half of the 48-bit operand per cycle while mul_en is set
  logic signed [HIST_W-1:0]            a_src;
  logic signed [iirbq_pkg::OPA_W-1:0]  a_op;
  logic signed [iirbq_pkg::OPB_W-1:0]  b_op;
  logic signed [PROD_W-1:0]            prod_q;

  assign a_src = cmd_i.gain ? x_q : hist_rd_q;
  assign a_op  = cmd_i.mul_hi ? {a_src[HIST_W-1], a_src[HIST_W-1:LO_W]}
                              : {1'b0, a_src[LO_W-1:0]};
  assign b_op  = cmd_i.gain ? {2'b00, gain_man_q} : {coef_rd_q[COEF_W-1], coef_rd_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= a_op * b_op;
    end
  end

  // accumulator
  logic signed [ACC_W-1:0] term_ext, term, x_ext, acc_q;

  assign term_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign term     = cmd_i.acc_shift ? (term_ext <<< LO_W) : term_ext;
  assign x_ext    = {{(ACC_W - HIST_W){x_q[HIST_W-1]}}, x_q} <<< COEF_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.acc_op)
      iirbq_pkg::ACC_HOLD:   ;
      iirbq_pkg::ACC_LOAD_X: acc_q <= x_ext;
      iirbq_pkg::ACC_LOAD:   acc_q <= term;
      iirbq_pkg::ACC_ADD:    acc_q <= acc_q + term;
      iirbq_pkg::ACC_SUB:    acc_q <= acc_q - term;
      default: ;
    endcase
  end

  // round half up, arithmetic shift, saturate
  logic [SH_W-1:0]          sh;
  logic [ACC_W-1:0]         rnd;
  logic signed [ACC_W-1:0]  sum_q, shv;
  logic [HIST_W-1:0]        y_sat;
  logic [OUT_W-1:0]         o_sat;
  logic [ACC_W-HIST_W:0]    y_top;
  logic [ACC_W-OUT_W:0]     o_top;

  assign sh  = cmd_i.gain ? (SH_W'(iirbq_pkg::GAIN_FRAC) + SH_W'(gain_sh_q))
                          : SH_W'(COEF_FRAC_BITS);
  assign rnd = {{(ACC_W - 1){1'b0}}, 1'b1} << (sh - SH_W'(1));
  assign shv = sum_q >>> sh;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd_en) begin
      sum_q <= acc_q + rnd;
    end
  end

  assign y_top = shv[ACC_W-1:HIST_W-1];
  assign o_top = shv[ACC_W-1:OUT_W-1];

  always_comb begin
    if (&y_top || ~|y_top) begin
      y_sat = shv[HIST_W-1:0];
    end else if (shv[ACC_W-1]) begin
      y_sat = {1'b1, {(HIST_W - 1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(HIST_W - 1){1'b1}}};
    end
    if (&o_top || ~|o_top) begin
      o_sat = shv[OUT_W-1:0];
    end else if (shv[ACC_W-1]) begin
      o_sat = {1'b1, {(OUT_W - 1){1'b0}}};
    end else begin
      o_sat = {1'b0, {(OUT_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_sample) begin
      x_q <= {{(HIST_W - iirbq_pkg::SAMPLE_W){req_i.sample[iirbq_pkg::SAMPLE_W-1]}},
              req_i.sample};
    end else if (cmd_i.fin_en && !cmd_i.gain) begin
      x_q <= y_sat;
    end
  end

  // result register
  logic out_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_en && cmd_i.gain) begin
      rsp_data_o.filtered <= o_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.fin_en && cmd_i.gain) begin
      out_vld_q <= 1'b1;
    end else if (rsp_rdy_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign rsp_vld_o      = out_vld_q;
  assign sts_o.out_free = !out_vld_q || rsp_rdy_i;

endmodule

FILE: test/iir_biquad_cascade_filter_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the biquad cascade filter core: random traffic, scored results.
module iir_biquad_cascade_filter_core_tb;

  localparam int unsigned SECTIONS     = 8;
  localparam int unsigned FRAC_BITS    = 28;
  localparam int unsigned REQ_W        = $bits(iirbq_pkg::req_t);
  localparam int unsigned PHASES       = 12;
  localparam int unsigned MIX_ITEMS    = 56;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam logic [iirbq_pkg::ACT_W-1:0] ACT_NONE = 2'd3;

  localparam longint Q_ONE  = 64'sd268435456;
  localparam longint A2_LIM = 64'sd241591910;
  localparam longint B_LIM  = 64'sd536870912;

  localparam logic signed [127:0] HIST_MAX = 128'sh7FFF_FFFF_FFFF;
  localparam logic signed [127:0] HIST_MIN = -128'sh8000_0000_0000;
  localparam logic signed [127:0] OUT_MAX  = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] OUT_MIN  = -128'sh8000_0000;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [iirbq_pkg::CFG_AW-1:0] cfg_addr_i  = '0;
  logic [iirbq_pkg::CFG_DW-1:0] cfg_wdata_i = '0;

  iirbq_stream_if #(.T(iirbq_pkg::req_t)) req_if ();
  iirbq_stream_if #(.T(iirbq_pkg::rsp_t)) rsp_if ();

  logic            req_valid = 1'b0;
  iirbq_pkg::req_t req_data  = '0;
  logic            rsp_ready = 1'b0;

  assign req_if.valid = req_valid;
  assign req_if.data  = req_data;
  assign rsp_if.ready = rsp_ready;

  iir_biquad_cascade_filter_core #(
    .MAX_SECTIONS  (SECTIONS),
    .COEF_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // filter state mirror
  logic signed [iirbq_pkg::COEF_W-1:0] coef_mem [4*SECTIONS];
  logic signed [iirbq_pkg::HIST_W-1:0] hist_mem [4*SECTIONS];
  logic [iirbq_pkg::NSEC_W-1:0]        m_nsec = '0;
  logic [iirbq_pkg::GMAN_W-1:0]        m_gman = '1;
  logic [iirbq_pkg::GSH_W-1:0]         m_gsh  = '0;

  iirbq_pkg::req_t                        pending_req [$];
  logic signed [iirbq_pkg::OUT_W-1:0]     filtered_q [$];

  logic        send_burst = 1'b0;
  logic        recv_burst = 1'b0;
  logic        hold_arm   = 1'b0;
  int unsigned hold_left;
  int unsigned req_gap;
  int unsigned rsp_stall;
  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;

  initial begin
    for (int i = 0; i < 4*SECTIONS; i++) begin
      coef_mem[i] = '0;
      hist_mem[i] = '0;
    end
  end

  function automatic logic signed [127:0] tap_product(
      input logic signed [iirbq_pkg::HIST_W-1:0] h,
      input logic signed [iirbq_pkg::COEF_W-1:0] c);
    logic signed [127:0] hw, cw;
    hw = h;
    cw = c;
    return hw * cw;
  endfunction

  // round half up, floor shift, clamp
  function automatic logic signed [127:0] round_sat(input logic signed [127:0] v,
                                                    input int unsigned s,
                                                    input logic signed [127:0] hi,
                                                    input logic signed [127:0] lo);
    logic signed [127:0] r;
    r = (v + (128'sd1 <<< (s - 1))) >>> s;
    if (r > hi) r = hi;
    else if (r < lo) r = lo;
    return r;
  endfunction

  task automatic predict_request(input iirbq_pkg::req_t r);
    logic signed [127:0] acc, x, y;
    int unsigned n;
    logic [4:0] base;
    case (r.action)
      iirbq_pkg::ACT_LOAD: coef_mem[{r.coef_section, r.coef_which}] = r.coef_value;
      iirbq_pkg::ACT_CLEAR: for (int i = 0; i < 4*SECTIONS; i++) hist_mem[i] = '0;
      iirbq_pkg::ACT_FILTER: begin
        n = (m_nsec > SECTIONS) ? SECTIONS : m_nsec;
        x = r.sample;
        for (int k = 0; k < n; k++) begin
          base = 5'(k * 4);
          acc = x <<< FRAC_BITS;
          acc = acc + tap_product(hist_mem[base + iirbq_pkg::TAP_X1],
                                  coef_mem[base + iirbq_pkg::TAP_X1]);
          acc = acc + tap_product(hist_mem[base + iirbq_pkg::TAP_X2],
                                  coef_mem[base + iirbq_pkg::TAP_X2]);
          acc = acc - tap_product(hist_mem[base + iirbq_pkg::TAP_Y1],
                                  coef_mem[base + iirbq_pkg::TAP_Y1]);
          acc = acc - tap_product(hist_mem[base + iirbq_pkg::TAP_Y2],
                                  coef_mem[base + iirbq_pkg::TAP_Y2]);
          y = round_sat(acc, FRAC_BITS, HIST_MAX, HIST_MIN);
          hist_mem[base + iirbq_pkg::TAP_X2] = hist_mem[base + iirbq_pkg::TAP_X1];
          hist_mem[base + iirbq_pkg::TAP_X1] = x[iirbq_pkg::HIST_W-1:0];
          hist_mem[base + iirbq_pkg::TAP_Y2] = hist_mem[base + iirbq_pkg::TAP_Y1];
          hist_mem[base + iirbq_pkg::TAP_Y1] = y[iirbq_pkg::HIST_W-1:0];
          x = y;
        end
        acc = x * $signed({97'd0, m_gman});
        y = round_sat(acc, iirbq_pkg::GAIN_FRAC + m_gsh, OUT_MAX, OUT_MIN);
        filtered_q.push_back(y[iirbq_pkg::OUT_W-1:0]);
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else begin
      if (req_valid && req_if.ready) predict_request(req_data);
      if (!req_valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_valid <= 1'b0;
          req_gap   <= req_gap - 1;
        end else if (pending_req.size() != 0) begin
          req_data  <= pending_req.pop_front();
          req_valid <= 1'b1;
          req_gap   <= send_burst ? 0 : $urandom_range(0, 8);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_left <= 0;
    else if (hold_arm) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int unsigned stall_n;
    logic signed [iirbq_pkg::OUT_W-1:0] want;
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
      rsp_stall <= 0;
    end else begin
      stall_n = rsp_stall;
      if (rsp_if.valid && rsp_ready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d", $time,
                   rsp_if.data.filtered);
          fail_cnt++;
        end else begin
          want = filtered_q.pop_front();
          if (rsp_if.data.filtered !== want) begin
            $display("%0t: filtered: expected %0d, actual %0d", $time, want,
                     rsp_if.data.filtered);
            fail_cnt++;
          end
        end
        stall_n = recv_burst ? 0 : $urandom_range(0, 8);
      end else if (stall_n != 0) begin
        stall_n--;
      end
      rsp_stall <= stall_n;
      rsp_ready <= (stall_n == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("iir_biquad_cascade_filter_core: mismatch");
      $finish;
    end
  end

  function automatic iirbq_pkg::req_t noise_req(input logic [iirbq_pkg::ACT_W-1:0] act);
    iirbq_pkg::req_t r;
    r = REQ_W'({$urandom, $urandom, $urandom});
    r.action = act;
    return r;
  endfunction

  task automatic send_sample(input logic [iirbq_pkg::SAMPLE_W-1:0] x);
    iirbq_pkg::req_t r;
    r = noise_req(iirbq_pkg::ACT_FILTER);
    r.sample = x;
    pending_req.push_back(r);
  endtask

  task automatic send_load(input logic [iirbq_pkg::CSEC_W-1:0] sec,
                           input logic [iirbq_pkg::TAP_W-1:0] which,
                           input logic [iirbq_pkg::COEF_W-1:0] value);
    iirbq_pkg::req_t r;
    r = noise_req(iirbq_pkg::ACT_LOAD);
    r.coef_section = sec;
    r.coef_which   = which;
    r.coef_value   = value;
    pending_req.push_back(r);
  endtask

  task automatic send_op(input logic [iirbq_pkg::ACT_W-1:0] act);
    pending_req.push_back(noise_req(act));
  endtask

  function automatic logic [iirbq_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2, 3: return $urandom;
      default: return 32'($urandom_range(0, 4000)) - 32'd2000;
    endcase
  endfunction

  task automatic write_reg(input logic [iirbq_pkg::CFG_AW-1:0] addr,
                           input logic [iirbq_pkg::CFG_DW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    case (addr)
      iirbq_pkg::CFG_NUM_SECTIONS:  m_nsec = value[iirbq_pkg::NSEC_W-1:0];
      iirbq_pkg::CFG_GAIN_MANTISSA: m_gman = value[iirbq_pkg::GMAN_W-1:0];
      iirbq_pkg::CFG_GAIN_SHIFT:    m_gsh  = value[iirbq_pkg::GSH_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    while (pending_req.size() != 0 || req_valid || filtered_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned pick;
    logic [iirbq_pkg::NSEC_W-1:0] nsec;
    logic [iirbq_pkg::CFG_DW-1:0] gman;
    logic [iirbq_pkg::GSH_W-1:0]  gsh;
    logic wild;
    longint a1, a2, b1, b2, lim;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no sections: straight to gain at reset settings
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    drain_all();

    // coefficient extremes, runaway feedback into 48-bit saturation, clear, unused action
    write_reg(iirbq_pkg::CFG_NUM_SECTIONS, iirbq_pkg::CFG_DW'(2));
    send_load(3'd0, iirbq_pkg::TAP_X1, 32'h7FFF_FFFF);
    send_load(3'd0, iirbq_pkg::TAP_X2, 32'h8000_0000);
    send_load(3'd0, iirbq_pkg::TAP_Y1, 32'h8000_0000);
    send_load(3'd0, iirbq_pkg::TAP_Y2, 32'h0000_0000);
    send_load(3'd7, iirbq_pkg::TAP_Y2, 32'h7FFF_FFFF);
    repeat (6) send_sample(32'h7FFF_FFFF);
    send_op(iirbq_pkg::ACT_CLEAR);
    send_op(ACT_NONE);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_all();
      case (phase)
        0: begin
          nsec = iirbq_pkg::NSEC_W'(SECTIONS);
          gman = '1;
          gsh  = '0;
        end
        1: begin
          nsec = '1;
          gman = '0;
          gsh  = '1;
        end
        2: begin
          nsec = '0;
          gman = iirbq_pkg::CFG_DW'($urandom);
          gsh  = '0;
        end
        default: begin
          nsec = ($urandom_range(0, 4) == 0)
                 ? iirbq_pkg::NSEC_W'($urandom_range(SECTIONS + 1, 15))
                 : iirbq_pkg::NSEC_W'($urandom_range(0, SECTIONS));
          case ($urandom_range(0, 3))
            0: gman = '1;
            1: gman = iirbq_pkg::CFG_DW'($urandom_range(0, 255));
            default: gman = iirbq_pkg::CFG_DW'($urandom);
          endcase
          gsh = ($urandom_range(0, 3) == 0) ? iirbq_pkg::GSH_W'($urandom_range(0, 63))
                                            : iirbq_pkg::GSH_W'($urandom_range(0, 3));
        end
      endcase
      write_reg(iirbq_pkg::CFG_NUM_SECTIONS, iirbq_pkg::CFG_DW'(nsec));
      write_reg(iirbq_pkg::CFG_GAIN_MANTISSA, gman);
      write_reg(iirbq_pkg::CFG_GAIN_SHIFT, iirbq_pkg::CFG_DW'(gsh));
      send_burst = (phase == 2) || ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      wild       = (phase == 1) || ($urandom_range(0, 3) == 0);

      // full coefficient set: stable sections unless wild
      for (int k = 0; k < SECTIONS; k++) begin
        a2  = longint'($urandom_range(0, 32'(2 * A2_LIM))) - A2_LIM;
        lim = (Q_ONE + a2) * 19 / 20;
        a1  = longint'($urandom_range(0, 32'(2 * lim))) - lim;
        b1  = longint'($urandom_range(0, 32'(2 * B_LIM))) - B_LIM;
        b2  = longint'($urandom_range(0, 32'(2 * B_LIM))) - B_LIM;
        send_load(iirbq_pkg::CSEC_W'(k), iirbq_pkg::TAP_X1, wild ? $urandom : 32'(b1));
        send_load(iirbq_pkg::CSEC_W'(k), iirbq_pkg::TAP_X2, wild ? $urandom : 32'(b2));
        send_load(iirbq_pkg::CSEC_W'(k), iirbq_pkg::TAP_Y1, wild ? $urandom : 32'(a1));
        send_load(iirbq_pkg::CSEC_W'(k), iirbq_pkg::TAP_Y2, wild ? $urandom : 32'(a2));
      end
      send_op(iirbq_pkg::ACT_CLEAR);

      for (int k = 0; k < MIX_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 86) send_sample(random_sample());
        else if (pick < 90)
          send_load(iirbq_pkg::CSEC_W'($urandom_range(0, 7)),
                    iirbq_pkg::TAP_W'($urandom_range(0, 3)), $urandom);
        else if (pick < 96) send_op(iirbq_pkg::ACT_CLEAR);
        else send_op(ACT_NONE);
      end

      if (phase == 2) begin
        hold_arm = 1'b1;
        @(negedge clk_i);
        hold_arm = 1'b0;
      end
    end

    drain_all();
    if (fail_cnt == 0 && filtered_q.size() == 0) begin
      $display("iir_biquad_cascade_filter_core: match");
    end else begin
      $display("iir_biquad_cascade_filter_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/iirbq_pkg.sv
sv/iirbq_stream_if.sv
sv/iirbq_ctrl.sv
sv/iirbq_dp.sv
sv/iir_biquad_cascade_filter_core.sv
test/iir_biquad_cascade_filter_core_tb.sv
